[sv/assert_macros.svh]
// Shared assertion macros for the divider checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define RID_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define RID_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rid_pkg.sv]
package rid_pkg;

  // Control carried alongside each operand pair down the cell chain.
  typedef struct packed {
    logic valid;
    logic q_neg;
    logic r_neg;
  } rid_ctl_t;

endpackage

[sv/rid_if.sv]
interface rid_req_if #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 32
);
  logic                      valid;
  logic                      ready;
  logic [DIVIDEND_WIDTH-1:0] dividend_value;
  logic [DIVISOR_WIDTH-1:0]  divisor_value;

  modport source (output valid, output dividend_value, output divisor_value, input ready);
  modport sink   (input valid, input dividend_value, input divisor_value, output ready);
endinterface

interface rid_rsp_if #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 32
);
  logic                      valid;
  logic                      ready;
  logic [DIVIDEND_WIDTH-1:0] quotient_value;
  logic [DIVISOR_WIDTH-1:0]  remainder_value;

  modport source (output valid, output quotient_value, output remainder_value, input ready);
  modport sink   (input valid, input quotient_value, input remainder_value, output ready);
endinterface

[sv/rid_cell.sv]
module rid_cell #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  rid_pkg::rid_ctl_t         ctl_in,
  input  logic [DIVIDEND_WIDTH-1:0] aq_in,
  input  logic [DIVISOR_WIDTH-1:0]  rem_in,
  input  logic [DIVISOR_WIDTH-1:0]  dvs_in,
  output rid_pkg::rid_ctl_t         ctl_out,
  output logic [DIVIDEND_WIDTH-1:0] aq_out,
  output logic [DIVISOR_WIDTH-1:0]  rem_out,
  output logic [DIVISOR_WIDTH-1:0]  dvs_out
);

  localparam int N = DIVIDEND_WIDTH;
  localparam int M = DIVISOR_WIDTH;

  logic [M:0]           rem_shift;
  logic [M+1:0]         diff;
  logic                 ge;
  logic [N-1:0]         aq_next;
  logic [M-1:0]         rem_next;
  rid_pkg::rid_ctl_t    ctl;
  logic [N-1:0]         aq;
  logic [M-1:0]         rem;
  logic [M-1:0]         dvs;

  // Bring down the next dividend bit and trial-subtract the divisor.
  always_comb begin
    rem_shift = {rem_in, aq_in[N-1]};
    diff      = {1'b0, rem_shift} - {2'b00, dvs_in};
    ge        = ~diff[M+1];
    rem_next  = ge ? diff[M-1:0] : rem_shift[M-1:0];
    // Consumed dividend bit leaves at the top, quotient bit enters at the bottom.
    aq_next   = {aq_in[N-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aq  <= aq_next;
      rem <= rem_next;
      dvs <= dvs_in;
    end
  end

  assign ctl_out = ctl;
  assign aq_out  = aq;
  assign rem_out = rem;
  assign dvs_out = dvs;

endmodule

[sv/rid_out_buf.sv]
module rid_out_buf #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rid_pkg::rid_ctl_t         ctl_in,
  input  logic [DIVIDEND_WIDTH-1:0] q_mag,
  input  logic [DIVISOR_WIDTH-1:0]  r_mag,
  output logic                      advance,
  rid_rsp_if.source                 rsp
);

  localparam int N = DIVIDEND_WIDTH;
  localparam int M = DIVISOR_WIDTH;
  localparam logic [N-1:0] ONE_N = {{(N-1){1'b0}}, 1'b1};
  localparam logic [M-1:0] ONE_M = {{(M-1){1'b0}}, 1'b1};

  logic [N-1:0] q_fix;
  logic [M-1:0] r_fix;
  logic         push;
  logic         take;
  logic         out_valid;
  logic [N-1:0] out_q;
  logic [M-1:0] out_r;
  logic         skid_valid;
  logic [N-1:0] skid_q;
  logic [M-1:0] skid_r;

  // Apply the signs to the magnitudes.
  always_comb begin
    q_fix = ctl_in.q_neg ? (~q_mag + ONE_N) : q_mag;
    r_fix = ctl_in.r_neg ? (~r_mag + ONE_M) : r_mag;
  end

  assign advance = ~skid_valid;
  assign push    = advance & ctl_in.valid;
  assign take    = out_valid & rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      // Output held: park the arriving result in the skid slot.
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      if (skid_valid) begin
        out_q <= skid_q;
        out_r <= skid_r;
      end else begin
        out_q <= q_fix;
        out_r <= r_fix;
      end
    end else if (push) begin
      skid_q <= q_fix;
      skid_r <= r_fix;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.quotient_value  = out_q;
  assign rsp.remainder_value = out_r;

endmodule

[sv/restoring_integer_divider.sv]
// Pipelined restoring divider, signed or unsigned.
// Requests arrive on req (valid/ready with dividend_value and divisor_value);
// results leave on rsp (valid/ready with quotient_value and remainder_value),
// one result per request, in request order.
// cfg_we/cfg_wdata write signed_mode: 1 for two's complement operands,
// 0 for unsigned. Write it only while no request is in flight.
// A zero divisor gives an all-ones magnitude quotient and the dividend as
// remainder, signs applied as for any other divisor.
// Pipeline: an entry stage takes the operand magnitudes, then one cell per
// quotient bit (DIVIDEND_WIDTH cells), then the output register.
// Throughput: one request per cycle, set by the cell chain where each cell
// does one trial subtraction and hands its partial remainder on.
// When rsp stalls, a skid slot takes one more result, then req.ready drops
// and the whole chain holds until the output drains.
// Reset (rst, synchronous) empties the chain and clears signed_mode.
module restoring_integer_divider #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  rid_req_if.sink   req,
  rid_rsp_if.source rsp
);

  localparam int N = DIVIDEND_WIDTH;
  localparam int M = DIVISOR_WIDTH;
  localparam logic [N-1:0] ONE_N = {{(N-1){1'b0}}, 1'b1};
  localparam logic [M-1:0] ONE_M = {{(M-1){1'b0}}, 1'b1};

  logic              signed_mode;
  logic              advance;
  logic              a_neg;
  logic              b_neg;
  logic [N-1:0]      a_mag;
  logic [M-1:0]      b_mag;
  rid_pkg::rid_ctl_t ctl_s [0:N];
  logic [N-1:0]      aq_s  [0:N];
  logic [M-1:0]      rem_s [0:N];
  logic [M-1:0]      dvs_s [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      signed_mode <= 1'b0;
    end else if (cfg_we) begin
      signed_mode <= cfg_wdata;
    end
  end

  assign req.ready = advance;

  always_comb begin
    a_neg = signed_mode & req.dividend_value[N-1];
    b_neg = signed_mode & req.divisor_value[M-1];
    a_mag = a_neg ? (~req.dividend_value + ONE_N) : req.dividend_value;
    b_mag = b_neg ? (~req.divisor_value + ONE_M) : req.divisor_value;
  end

  // Entry stage: magnitudes and sign flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0] <= '0;
    end else if (advance) begin
      ctl_s[0].valid <= req.valid;
      ctl_s[0].q_neg <= a_neg ^ b_neg;
      ctl_s[0].r_neg <= a_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      aq_s[0]  <= a_mag;
      rem_s[0] <= '0;
      dvs_s[0] <= b_mag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    rid_cell #(
      .DIVIDEND_WIDTH(N),
      .DIVISOR_WIDTH (M)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (advance),
      .ctl_in (ctl_s[i]),
      .aq_in  (aq_s[i]),
      .rem_in (rem_s[i]),
      .dvs_in (dvs_s[i]),
      .ctl_out(ctl_s[i+1]),
      .aq_out (aq_s[i+1]),
      .rem_out(rem_s[i+1]),
      .dvs_out(dvs_s[i+1])
    );
  end

  rid_out_buf #(
    .DIVIDEND_WIDTH(N),
    .DIVISOR_WIDTH (M)
  ) u_out (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_s[N]),
    .q_mag  (aq_s[N]),
    .r_mag  (rem_s[N]),
    .advance(advance),
    .rsp    (rsp)
  );

endmodule

[sv/rid_checker.sv]
`include "assert_macros.svh"

module rid_checker #(
  parameter int DIVIDEND_WIDTH = 32,
  parameter int DIVISOR_WIDTH  = 32
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [DIVIDEND_WIDTH-1:0] rsp_quotient,
  input logic [DIVISOR_WIDTH-1:0]  rsp_remainder
);

  logic req_fire;

  assign req_fire = req_valid & req_ready;

  `RID_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
  `RID_ASSERT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready |=> $stable(rsp_quotient) && $stable(rsp_remainder), "response changed while stalled")
  `RID_ASSERT(a_backpressure, clk, rst, !req_ready |-> rsp_valid && !req_fire, "request refused with no result pending")
  `RID_ASSERT(a_after_reset, clk, rst, $past(rst) |-> !rsp_valid && req_ready, "not empty after reset")

endmodule

bind restoring_integer_divider rid_checker #(
  .DIVIDEND_WIDTH(DIVIDEND_WIDTH),
  .DIVISOR_WIDTH (DIVISOR_WIDTH)
) u_rid_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_quotient (rsp.quotient_value),
  .rsp_remainder(rsp.remainder_value)
);

[tb/restoring_integer_divider_tb.sv]
module restoring_integer_divider_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = 32;
  localparam int DW = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 150;
  localparam int PHASES = 6;

  typedef struct packed {
    logic [NW-1:0] quotient;
    logic [DW-1:0] remainder;
  } division_result_t;

  class divider_scoreboard;
    bit signed_mode;
    division_result_t awaited[$];
    int mismatches;
    int requests;
    int results;

    function division_result_t divide_pair(logic [NW-1:0] dividend, logic [DW-1:0] divisor);
      division_result_t res;
      logic dividend_neg;
      logic divisor_neg;
      logic [NW-1:0] dividend_mag;
      logic [DW-1:0] divisor_mag;
      dividend_neg = signed_mode && dividend[NW-1];
      divisor_neg = signed_mode && divisor[DW-1];
      // most negative operand stays 2^(w-1) as an unsigned magnitude
      dividend_mag = dividend_neg ? NW'(-dividend) : dividend;
      divisor_mag = divisor_neg ? DW'(-divisor) : divisor;
      if (divisor_mag == '0) begin
        res.quotient = '1;
        res.remainder = DW'(dividend_mag);
      end else begin
        res.quotient = NW'(dividend_mag / divisor_mag);
        res.remainder = DW'(dividend_mag % divisor_mag);
      end
      if (dividend_neg != divisor_neg)
        res.quotient = NW'(-res.quotient);
      if (dividend_neg)
        res.remainder = DW'(-res.remainder);
      return res;
    endfunction

    function void note_request(logic [NW-1:0] dividend, logic [DW-1:0] divisor);
      awaited.insert(awaited.size(), divide_pair(dividend, divisor));
      requests++;
    endfunction

    function void check_result(logic [NW-1:0] quotient, logic [DW-1:0] remainder);
      division_result_t want;
      results++;
      if (awaited.size() == 0) begin
        $error("unexpected result: quotient_value %h remainder_value %h", quotient, remainder);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (quotient !== want.quotient) begin
        $error("quotient_value: expected %h, actual %h", want.quotient, quotient);
        mismatches++;
      end
      if (remainder !== want.remainder) begin
        $error("remainder_value: expected %h, actual %h", want.remainder, remainder);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  rid_req_if #(.DIVIDEND_WIDTH(NW), .DIVISOR_WIDTH(DW)) req_ch ();
  rid_rsp_if #(.DIVIDEND_WIDTH(NW), .DIVISOR_WIDTH(DW)) rsp_ch ();

  restoring_integer_divider #(
    .DIVIDEND_WIDTH(NW),
    .DIVISOR_WIDTH(DW)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  divider_scoreboard quotient_board;
  bit sender_gaps;
  bit receiver_stalls;

  // corner operand pairs, run once in each mode
  logic [NW-1:0] corner_dividends [12] = '{
    32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
    32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
    32'h7fff_ffff, 32'h1234_5678, 32'h0000_0005, 32'hffff_fff9
  };
  logic [DW-1:0] corner_divisors [12] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
    32'hffff_ffff, 32'h0000_0000, 32'hffff_fffd, 32'h0000_0002
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] shaped_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0001;
      2: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      3, 4, 5: begin
        // short magnitudes, either sign
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1))
          v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_request(input logic [NW-1:0] dividend, input logic [DW-1:0] divisor);
    while (sender_gaps && $urandom_range(0, 99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.dividend_value <= dividend;
    req_ch.divisor_value <= divisor;
    do
      @(posedge clk);
    while (!req_ch.ready);
    quotient_board.note_request(dividend, divisor);
  endtask

  // drop valid and hold until every request has come back
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    while (quotient_board.awaited.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_signed_mode(input bit mode);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    quotient_board.signed_mode = mode;
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready)
        quotient_board.check_result(rsp_ch.quotient_value, rsp_ch.remainder_value);
      rsp_ch.ready <= !(receiver_stalls && $urandom_range(0, 99) < 11);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit failed;
    quotient_board = new;
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.dividend_value <= '0;
    req_ch.divisor_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int mode = 0; mode < 2; mode++) begin
      write_signed_mode(mode[0]);
      foreach (corner_dividends[i])
        send_request(corner_dividends[i], corner_divisors[i]);
      drain_requests();
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      write_signed_mode(phase[0]);
      // one phase runs flat out on both sides
      sender_gaps = (phase != 2);
      receiver_stalls = (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == PHASE_ITEMS / 2)
          drain_requests();
        send_request(shaped_operand(), shaped_operand());
      end
      drain_requests();
    end

    repeat (NW + 8) @(posedge clk);
    if (quotient_board.awaited.size() != 0)
      $error("%0d results never arrived", quotient_board.awaited.size());
    failed = quotient_board.mismatches != 0 || quotient_board.awaited.size() != 0;

    $display("Divided %0d operand pairs, %0d results checked, %0d mismatches.",
             quotient_board.requests, quotient_board.results, quotient_board.mismatches);
    $display("Both modes, zero divisors, most negative operands, random idles and a mid-run drain.");
    if (!failed)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
